@@ design/sor_pkg.sv @@
// ----------------------------------------------------------------------------
// sor_pkg
// Shared types, constants and the quarter-wave sine table for the sine
// oscillator with ramps.
// ----------------------------------------------------------------------------
package sor_pkg;

  // Fixed widths
  localparam int PHASE_BITS      = 32;
  localparam int TABLE_ADDR_BITS = 10;
  localparam int SAMPLE_BITS     = 16;
  localparam int MAX_BLOCK       = 4096;
  localparam int STEP_BITS       = 31;
  localparam int LEVEL_BITS      = 16;
  localparam int GAIN_BITS       = 16;
  localparam int LEN_BITS        = 13;
  localparam int QUARTER         = 1 << (TABLE_ADDR_BITS - 2);
  localparam int MAG_BITS        = SAMPLE_BITS - 1;

  // Table build constants
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned ONE_Q30     = 64'd1 << 30;
  localparam longint unsigned AMP         = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;
  localparam longint unsigned TAYLOR_DIV [5] = '{64'd110, 64'd72, 64'd42, 64'd20, 64'd6};

  // Ramp mode codes
  localparam logic [1:0] MODE_STEADY = 2'd0;
  localparam logic [1:0] MODE_STEP   = 2'd1;
  localparam logic [1:0] MODE_LEVEL  = 2'd2;

  // Register indexes on the config port
  localparam logic REG_MASTER_GAIN  = 1'b0;
  localparam logic REG_BLOCK_LENGTH = 1'b1;

  // Reset values of the config registers
  localparam logic [GAIN_BITS-1:0] GAIN_RESET = 16'd8192;
  localparam logic [LEN_BITS-1:0]  LEN_RESET  = 13'd512;

  typedef enum logic {
    KIND_RUN,
    KIND_LATCH
  } kind_e;

  // Input word as it travels from the front to the back
  typedef struct packed {
    kind_e                  kind;
    logic [STEP_BITS-1:0]   target_step;
    logic [LEVEL_BITS-1:0]  target_level;
  } item_t;

  // Config register values
  typedef struct packed {
    logic [GAIN_BITS-1:0] master_gain;
    logic [LEN_BITS-1:0]  block_length;
  } cfg_t;

  typedef logic [QUARTER:0][MAG_BITS-1:0] qwave_t;

  // Quarter wave, Q30 Taylor series up to x^11, evaluated at elaboration
  function automatic qwave_t build_qwave();
    qwave_t          tab;
    longint unsigned ii;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned s;
    longint unsigned v;
    tab = '0;
    for (int i = 0; i <= QUARTER; i++) begin
      ii = longint'(i);
      x  = (ii * HALF_PI_Q30) / QUARTER;
      x2 = (x * x) >> 30;
      t  = ONE_Q30;
      for (int k = 0; k < 5; k++) begin
        t = ONE_Q30 - (((x2 * t) >> 30) / TAYLOR_DIV[k]);
      end
      s = (x * t) >> 30;
      v = (s * AMP + (64'd1 << 29)) >> 30;
      if (v > AMP) begin
        v = AMP;
      end
      tab[i] = v[MAG_BITS-1:0];
    end
    return tab;
  endfunction

  localparam qwave_t QWAVE = build_qwave();

  // Full-wave lookup from the quarter table by symmetry
  function automatic logic signed [SAMPLE_BITS-1:0] sine_at(
    input logic [TABLE_ADDR_BITS-1:0] idx
  );
    logic [1:0]                 quad;
    logic [TABLE_ADDR_BITS-3:0] r;
    logic [TABLE_ADDR_BITS-2:0] a;
    logic [MAG_BITS-1:0]        mag;
    logic signed [SAMPLE_BITS-1:0] pos;
    quad = idx[TABLE_ADDR_BITS-1 -: 2];
    r    = idx[TABLE_ADDR_BITS-3:0];
    a    = quad[0] ? ((TABLE_ADDR_BITS-1)'(QUARTER) - {1'b0, r}) : {1'b0, r};
    mag  = QWAVE[a];
    pos  = $signed({1'b0, mag});
    return quad[1] ? -pos : pos;
  endfunction

endpackage

@@ design/sor_front.sv @@
// ----------------------------------------------------------------------------
// sor_front
// Input side: takes words from the push/full port, tags each as a latch
// (block start) or a plain run sample, and queues them for the back end.
// ----------------------------------------------------------------------------
module sor_front import sor_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  logic                  block_start_i,
  input  logic [STEP_BITS-1:0]  target_step_i,
  input  logic [LEVEL_BITS-1:0] target_level_i,
  output logic                  item_valid_o,
  output item_t                 item_o,
  input  logic                  item_pop_i
);

  localparam int DEPTH = 2;

  item_t      mem_q [DEPTH];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] fill_q;
  logic       do_push, do_pop;
  item_t      new_item;

  // Classify the incoming word
  always_comb begin
    new_item.kind         = block_start_i ? KIND_LATCH : KIND_RUN;
    new_item.target_step  = target_step_i;
    new_item.target_level = target_level_i;
  end

  assign full         = (fill_q == 2'(DEPTH));
  assign item_valid_o = (fill_q != 2'd0);
  assign item_o       = mem_q[rd_ptr_q];
  assign do_push      = push && !full;
  assign do_pop       = item_pop_i && item_valid_o;

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= new_item;
    end
  end

  // Queue pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
      if (do_push && !do_pop) fill_q <= fill_q + 2'd1;
      else if (do_pop && !do_push) fill_q <= fill_q - 2'd1;
    end
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= 2'(DEPTH))
    else $error("front queue overfilled");

endmodule

@@ design/sor_div.sv @@
// ----------------------------------------------------------------------------
// sor_div
// Restoring divider, one quotient bit per cycle: 32-bit magnitude divided
// by the block length.
// ----------------------------------------------------------------------------
module sor_div import sor_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [31:0]         dividend_i,
  input  logic [LEN_BITS-1:0] divisor_i,
  output logic                done_o,
  output logic [31:0]         quotient_o
);

  logic                busy_q, done_q;
  logic [4:0]          cnt_q;
  logic [31:0]         quo_q;
  logic [LEN_BITS-1:0] rem_q, dsr_q;
  logic [LEN_BITS:0]   rem_sh;
  logic                ge;

  // One trial subtraction
  assign rem_sh = {rem_q, quo_q[31]};
  assign ge     = (rem_sh >= {1'b0, dsr_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: quotient shifts in where the dividend shifts out
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[30:0], ge};
      rem_q <= ge ? LEN_BITS'(rem_sh - {1'b0, dsr_q}) : rem_sh[LEN_BITS-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

@@ design/sor_back.sv @@
// ----------------------------------------------------------------------------
// sor_back
// Back end: latches targets, sets up ramps through the divider, looks up
// the sine, scales by level and gain, and advances phase and ramps.
// ----------------------------------------------------------------------------
module sor_back import sor_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cfg_t                          cfg_i,
  input  logic                          item_valid_i,
  input  item_t                         item_i,
  output logic                          item_pop_o,
  input  logic                          pop_i,
  output logic                          out_valid_o,
  output logic signed [SAMPLE_BITS-1:0] sample_o,
  output logic                          last_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_LOOK = 3'd2;
  localparam logic [2:0] ST_MUL1 = 3'd3;
  localparam logic [2:0] ST_MUL2 = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  localparam int P1_BITS = SAMPLE_BITS + LEVEL_BITS + 1;
  localparam int P2_BITS = P1_BITS + GAIN_BITS + 1;
  localparam int SHIFT   = 32 + SAMPLE_BITS - 16;
  localparam int HI_BITS = P2_BITS - SHIFT;

  // Control state
  logic [2:0]            state_q, state_d;
  logic [1:0]            mode_q, mode_d;
  logic [PHASE_BITS-1:0] phase_q, phase_d;
  logic [31:0]           step_q, step_d;
  logic [LEVEL_BITS-1:0] level_q, level_d;
  logic [STEP_BITS-1:0]  lat_step_q, lat_step_d;
  logic [LEVEL_BITS-1:0] lat_level_q, lat_level_d;
  logic signed [32:0]    step_inc_q, step_inc_d;
  logic signed [LEVEL_BITS:0] level_inc_q, level_inc_d;
  logic [LEN_BITS-1:0]   count_q, count_d;
  logic                  out_valid_q, out_valid_d;

  // Payload
  logic                          neg_q, neg_d;
  logic signed [SAMPLE_BITS-1:0] tv_q, tv_d;
  logic signed [P1_BITS-1:0]     prod1_q, prod1_d;
  logic signed [P2_BITS-1:0]     prod2_q, prod2_d;
  logic signed [SAMPLE_BITS-1:0] sample_q, sample_d;
  logic                          last_q, last_d;

  // Helpers
  logic [LEN_BITS-1:0]    eff_len;
  logic [32:0]            step_diff;
  logic [31:0]            step_mag;
  logic [LEVEL_BITS:0]    lvl_diff;
  logic [LEVEL_BITS-1:0]  lvl_mag;
  logic                   last;
  logic                   slot_free;
  logic signed [HI_BITS-1:0] hi;
  logic signed [SAMPLE_BITS-1:0] sat;
  logic                   div_start, div_done;
  logic [31:0]            div_dvd, div_quo;

  // Block length clamped to 1..MAX_BLOCK
  always_comb begin
    if (cfg_i.block_length == '0) begin
      eff_len = LEN_BITS'(1);
    end else if (cfg_i.block_length > LEN_BITS'(MAX_BLOCK)) begin
      eff_len = LEN_BITS'(MAX_BLOCK);
    end else begin
      eff_len = cfg_i.block_length;
    end
  end

  // Distance to the new targets, as sign and magnitude
  assign step_diff = {2'b00, item_i.target_step} - {1'b0, step_q};
  assign step_mag  = step_diff[32] ? 32'(-step_diff) : step_diff[31:0];
  assign lvl_diff  = {1'b0, item_i.target_level} - {1'b0, level_q};
  assign lvl_mag   = lvl_diff[LEVEL_BITS] ? LEVEL_BITS'(-lvl_diff) : lvl_diff[LEVEL_BITS-1:0];

  assign last      = ({1'b0, count_q} + (LEN_BITS+1)'(1)) >= {1'b0, eff_len};
  assign slot_free = !out_valid_q || pop_i;

  // Floor shift and saturation
  assign hi = prod2_q[P2_BITS-1:SHIFT];
  always_comb begin
    if (hi > HI_BITS'(32767)) begin
      sat = 16'sd32767;
    end else if (hi < -HI_BITS'(32768)) begin
      sat = -16'sd32768;
    end else begin
      sat = hi[SAMPLE_BITS-1:0];
    end
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    phase_d     = phase_q;
    step_d      = step_q;
    level_d     = level_q;
    lat_step_d  = lat_step_q;
    lat_level_d = lat_level_q;
    step_inc_d  = step_inc_q;
    level_inc_d = level_inc_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && !pop_i;
    neg_d       = neg_q;
    tv_d        = tv_q;
    prod1_d     = prod1_q;
    prod2_d     = prod2_q;
    sample_d    = sample_q;
    last_d      = last_q;
    item_pop_o  = 1'b0;
    div_start   = 1'b0;
    div_dvd     = step_mag;

    unique case (state_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          item_pop_o = 1'b1;
          state_d    = ST_LOOK;
          if (item_i.kind == KIND_LATCH) begin
            lat_step_d  = item_i.target_step;
            lat_level_d = item_i.target_level;
            count_d     = '0;
            if (step_diff != '0) begin
              mode_d    = MODE_STEP;
              div_start = 1'b1;
              neg_d     = step_diff[32];
              state_d   = ST_DIV;
            end else if (lvl_diff != '0) begin
              mode_d    = MODE_LEVEL;
              div_start = 1'b1;
              div_dvd   = {16'b0, lvl_mag};
              neg_d     = lvl_diff[LEVEL_BITS];
              state_d   = ST_DIV;
            end else begin
              mode_d = MODE_STEADY;
            end
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          if (mode_q == MODE_STEP) begin
            step_inc_d = neg_q ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
          end else begin
            level_inc_d = neg_q ? -$signed({1'b0, div_quo[LEVEL_BITS-1:0]})
                                : $signed({1'b0, div_quo[LEVEL_BITS-1:0]});
          end
          state_d = ST_LOOK;
        end
      end
      ST_LOOK: begin
        tv_d = sine_at(phase_q[PHASE_BITS-1 -: TABLE_ADDR_BITS]);
        if (mode_q == MODE_LEVEL) begin
          level_d = level_q + level_inc_q[LEVEL_BITS-1:0];
        end
        state_d = ST_MUL1;
      end
      ST_MUL1: begin
        prod1_d = tv_q * $signed({1'b0, level_q});
        if (mode_q == MODE_STEP) begin
          step_d = step_q + step_inc_q[31:0];
        end
        state_d = ST_MUL2;
      end
      ST_MUL2: begin
        prod2_d = prod1_q * $signed({1'b0, cfg_i.master_gain});
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          sample_d    = sat;
          last_d      = last;
          phase_d     = phase_q + step_q;
          if (last) begin
            if (mode_q == MODE_STEP) begin
              step_d = {1'b0, lat_step_q};
            end else if (mode_q == MODE_LEVEL) begin
              level_d = lat_level_q;
            end
            mode_d  = MODE_STEADY;
            count_d = '0;
          end else begin
            count_d = count_q + LEN_BITS'(1);
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= MODE_STEADY;
      phase_q     <= '0;
      step_q      <= '0;
      level_q     <= '0;
      lat_step_q  <= '0;
      lat_level_q <= '0;
      step_inc_q  <= '0;
      level_inc_q <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      phase_q     <= phase_d;
      step_q      <= step_d;
      level_q     <= level_d;
      lat_step_q  <= lat_step_d;
      lat_level_q <= lat_level_d;
      step_inc_q  <= step_inc_d;
      level_inc_q <= level_inc_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q    <= neg_d;
    tv_q     <= tv_d;
    prod1_q  <= prod1_d;
    prod2_q  <= prod2_d;
    sample_q <= sample_d;
    last_q   <= last_d;
  end

  // Ramp increment divider
  sor_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (eff_len),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign out_valid_o = out_valid_q;
  assign sample_o    = sample_q;
  assign last_o      = last_q;

  a_div_has_ramp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> mode_q != MODE_STEADY)
    else $error("divider running without a ramp");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q < LEN_BITS'(MAX_BLOCK))
    else $error("sample count out of range");

  a_block_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && slot_free && last) |=>
      (mode_q == MODE_STEADY && count_q == '0 && last_o))
    else $error("block end did not settle");

endmodule

@@ design/sine_oscillator_with_ramps.sv @@
// ----------------------------------------------------------------------------
// sine_oscillator_with_ramps
// Phase-accumulator sine oscillator with per-block linear ramps of the
// tuning word or the level, and an APB register port.
// ----------------------------------------------------------------------------
// Each word pushed in yields one sample word. A word without a block start,
// or with one whose targets match the current step and level, goes through
// the back end's idle, table lookup, two multiply and output states. A block
// start that begins a ramp first runs the restoring divider that computes
// the per-sample increment, ahead of the table lookup. The back end
// handles one word at a time; a two-word input queue and a one-word output
// register let the input and output sides stall independently. Registers:
// master_gain at 0x0, block_length at 0x4.
module sine_oscillator_with_ramps import sor_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input queue side
  input  logic                          push,
  output logic                          full,
  input  logic                          block_start_i,
  input  logic [STEP_BITS-1:0]          target_step_i,
  input  logic [LEVEL_BITS-1:0]         target_level_i,
  // Output queue side
  output logic                          empty,
  input  logic                          pop,
  output logic signed [SAMPLE_BITS-1:0] sample_o,
  output logic                          last_of_block_o,
  // Config port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  cfg_t  cfg_q;
  logic  cfg_wr;
  item_t item;
  logic  item_valid, item_pop, out_valid;

  // Config registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.master_gain  <= GAIN_RESET;
      cfg_q.block_length <= LEN_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_MASTER_GAIN:  cfg_q.master_gain  <= pwdata[GAIN_BITS-1:0];
        REG_BLOCK_LENGTH: cfg_q.block_length <= pwdata[LEN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    unique case (paddr[2])
      REG_MASTER_GAIN:  prdata = {16'b0, cfg_q.master_gain};
      REG_BLOCK_LENGTH: prdata = {19'b0, cfg_q.block_length};
      default:          prdata = '0;
    endcase
  end

  sor_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .block_start_i  (block_start_i),
    .target_step_i  (target_step_i),
    .target_level_i (target_level_i),
    .item_valid_o   (item_valid),
    .item_o         (item),
    .item_pop_i     (item_pop)
  );

  sor_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .pop_i        (pop),
    .out_valid_o  (out_valid),
    .sample_o     (sample_o),
    .last_o       (last_of_block_o)
  );

  assign empty = !out_valid;

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sine oscillator with ramps. A queue-fed driver
// pushes sample requests, a monitor pops sample words and checks each one
// against an in-bench model of the phase accumulator, the step and level
// ramps and the output scaling. Gain and block length are reprogrammed over
// the APB port between phases, extremes and out-of-range lengths included.
// ----------------------------------------------------------------------------
module tb;
  import sor_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 250;

  typedef struct {
    logic                  start;
    logic [STEP_BITS-1:0]  step;
    logic [LEVEL_BITS-1:0] level;
  } req_word_t;

  typedef struct {
    logic [SAMPLE_BITS-1:0] value;
    logic                   last;
  } sample_word_t;

  // DUT connections, the inputs all known from time zero
  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          push = 1'b0;
  logic                          full;
  logic                          block_start_i = 1'b0;
  logic [STEP_BITS-1:0]          target_step_i = '0;
  logic [LEVEL_BITS-1:0]         target_level_i = '0;
  logic                          empty;
  logic                          pop = 1'b0;
  logic signed [SAMPLE_BITS-1:0] sample_o;
  logic                          last_of_block_o;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [2:0]                    paddr = '0;
  logic [31:0]                   pwdata = '0;
  logic [31:0]                   prdata;
  logic                          pready;

  // Bench state
  req_word_t    req_q[$];
  sample_word_t expected_samples[$];
  req_word_t    next_req;
  sample_word_t got_word;
  int           error_count = 0;
  int           samples_seen = 0;
  int           tx_gap = 0;
  int           rx_gap = 0;
  int           rx_hold = 0;
  int           stall_cycles = 0;
  bit           idle_on = 1'b1;

  // Oscillator model state
  longint                 qwave [0:QUARTER];
  logic [GAIN_BITS-1:0]   cfg_gain = GAIN_RESET;
  logic [LEN_BITS-1:0]    cfg_len = LEN_RESET;
  logic [PHASE_BITS-1:0]  osc_phase = '0;
  logic [31:0]            cur_step = '0;
  logic [31:0]            lat_step = '0;
  logic [LEVEL_BITS-1:0]  cur_level = '0;
  logic [LEVEL_BITS-1:0]  lat_level = '0;
  longint                 step_inc = 0;
  int                     level_inc = 0;
  logic [1:0]             ramp = MODE_STEADY;
  logic [LEN_BITS-1:0]    count_in_block = '0;

  // Targets of the last generated block start
  logic [STEP_BITS-1:0]   gen_step = '0;
  logic [LEVEL_BITS-1:0]  gen_level = '0;

  sine_oscillator_with_ramps u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .block_start_i   (block_start_i),
    .target_step_i   (target_step_i),
    .target_level_i  (target_level_i),
    .empty           (empty),
    .pop             (pop),
    .sample_o        (sample_o),
    .last_of_block_o (last_of_block_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic flag_error(input string msg);
    if (error_count < 100) begin
      $display("ERROR @%0t: %s", $realtime, msg);
    end
    error_count++;
  endtask

  // Quarter-wave entry: Q30 Taylor series of sin up to x^11
  function automatic longint quarter_entry(input int i);
    longint unsigned dv [5];
    longint unsigned amp;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned s;
    longint unsigned v;
    dv  = '{64'd110, 64'd72, 64'd42, 64'd20, 64'd6};
    amp = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;
    x   = (64'(i) * 64'd1686629713) / 64'(QUARTER);
    x2  = (x * x) >> 30;
    t   = 64'd1 << 30;
    for (int k = 0; k < 5; k++) begin
      t = (64'd1 << 30) - (((x2 * t) >> 30) / dv[k]);
    end
    s = (x * t) >> 30;
    v = (s * amp + (64'd1 << 29)) >> 30;
    if (v > amp) begin
      v = amp;
    end
    return longint'(v);
  endfunction

  // Full-wave value by quadrant symmetry
  function automatic longint tone_at(input logic [TABLE_ADDR_BITS-1:0] idx);
    logic [1:0] quad;
    int         r;
    longint     v;
    quad = idx[TABLE_ADDR_BITS-1 -: 2];
    r    = int'(idx[TABLE_ADDR_BITS-3:0]);
    v    = quad[0] ? qwave[QUARTER - r] : qwave[r];
    return quad[1] ? -v : v;
  endfunction

  function automatic int block_len_in_force();
    int n;
    n = int'(cfg_len);
    if (n == 0) begin
      n = 1;
    end
    if (n > MAX_BLOCK) begin
      n = MAX_BLOCK;
    end
    return n;
  endfunction

  // Advance the oscillator by one accepted request and queue its sample
  function automatic void predict_sample(input logic start, input logic [STEP_BITS-1:0] step,
                                         input logic [LEVEL_BITS-1:0] level);
    int           len;
    longint       tv;
    longint       prod;
    longint       smp;
    logic         last;
    sample_word_t w;
    if (start) begin
      lat_step       = {1'b0, step};
      lat_level      = level;
      count_in_block = '0;
      len            = block_len_in_force();
      if (lat_step != cur_step) begin
        step_inc = (longint'(lat_step) - longint'(cur_step)) / longint'(len);
        ramp     = MODE_STEP;
      end else if (lat_level != cur_level) begin
        level_inc = (int'(lat_level) - int'(cur_level)) / len;
        ramp      = MODE_LEVEL;
      end else begin
        ramp = MODE_STEADY;
      end
    end
    len = block_len_in_force();
    tv  = tone_at(osc_phase[PHASE_BITS-1 -: TABLE_ADDR_BITS]);
    if (ramp == MODE_LEVEL) begin
      cur_level = LEVEL_BITS'(int'(cur_level) + level_inc);
    end
    // floor of the Q16 x Q16 product
    prod = tv * longint'(cur_level) * longint'(cfg_gain);
    smp  = prod >>> (32 + SAMPLE_BITS - 16);
    if (smp > 32767) begin
      smp = 32767;
    end
    if (smp < -32768) begin
      smp = -32768;
    end
    if (ramp == MODE_STEP) begin
      cur_step = 32'(longint'(cur_step) + step_inc);
    end
    osc_phase = osc_phase + cur_step;
    // block end: snap the ramped value
    last = (int'(count_in_block) + 1) >= len;
    if (last) begin
      if (ramp == MODE_STEP) begin
        cur_step = lat_step;
      end else if (ramp == MODE_LEVEL) begin
        cur_level = lat_level;
      end
      ramp           = MODE_STEADY;
      count_in_block = '0;
    end else begin
      count_in_block = count_in_block + 1'b1;
    end
    w.value = SAMPLE_BITS'(smp);
    w.last  = last;
    expected_samples.push_back(w);
  endfunction

  // Request driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) begin
        predict_sample(block_start_i, target_step_i, target_level_i);
      end
      if (push && full) begin
        // hold the word until taken
      end else if (tx_gap > 0) begin
        tx_gap--;
        push <= 1'b0;
      end else if (req_q.size() > 0 && idle_on && $urandom_range(0, 7) == 0) begin
        tx_gap = $urandom_range(0, 5);
        push <= 1'b0;
      end else if (req_q.size() > 0) begin
        next_req = req_q.pop_front();
        push           <= 1'b1;
        block_start_i  <= next_req.start;
        target_step_i  <= next_req.step;
        target_level_i <= next_req.level;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Sample monitor and checker
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) begin
        if (expected_samples.size() == 0) begin
          flag_error($sformatf("sample %0d arrived with none expected", sample_o));
        end else begin
          got_word = expected_samples.pop_front();
          if (sample_o !== got_word.value) begin
            flag_error($sformatf("sample %0d, expected %0d", sample_o,
                                 $signed(got_word.value)));
          end
          if (last_of_block_o !== got_word.last) begin
            flag_error($sformatf("last_of_block %b, expected %b", last_of_block_o,
                                 got_word.last));
          end
        end
        samples_seen++;
        // long back-pressure so the block fills and stalls its input
        if (samples_seen == 300 || samples_seen == 1000) begin
          rx_hold = HOLD_CYCLES;
        end
      end
      if (rx_hold > 0) begin
        rx_hold--;
        pop <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        pop <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        rx_gap = $urandom_range(0, 5);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty) || psel) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  // APB write then read back of one register
  task automatic set_register(input logic idx, input logic [31:0] value);
    logic [31:0] want;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx == REG_MASTER_GAIN) begin
      cfg_gain = value[GAIN_BITS-1:0];
      want     = 32'(value[GAIN_BITS-1:0]);
    end else begin
      cfg_len = value[LEN_BITS-1:0];
      want    = 32'(value[LEN_BITS-1:0]);
    end
    @(posedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== want) begin
      flag_error($sformatf("register %0d reads %h, expected %h", idx, prdata, want));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic wait_idle();
    while (req_q.size() > 0 || push || expected_samples.size() > 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic add_word(input logic start, input logic [STEP_BITS-1:0] step,
                          input logic [LEVEL_BITS-1:0] level);
    req_word_t w;
    w.start = start;
    w.step  = step;
    w.level = level;
    req_q.push_back(w);
  endtask

  // Block-start targets: often a repeat of the last one, so level ramps and
  // steady blocks come up as well as step ramps
  function automatic logic [STEP_BITS-1:0] pick_step();
    case ($urandom_range(0, 5))
      0, 1: ;
      2: gen_step = STEP_BITS'($urandom);
      3: gen_step = STEP_BITS'($urandom_range(0, 4096));
      4: gen_step = $urandom_range(0, 1) ? '1 : '0;
      default: gen_step = gen_step + STEP_BITS'($urandom_range(0, 600)) - 31'd300;
    endcase
    return gen_step;
  endfunction

  function automatic logic [LEVEL_BITS-1:0] pick_level();
    case ($urandom_range(0, 3))
      0, 1: ;
      2: gen_level = LEVEL_BITS'($urandom);
      default: gen_level = $urandom_range(0, 1) ? '1 : '0;
    endcase
    return gen_level;
  endfunction

  // Mostly whole blocks with random targets, some stray words
  task automatic queue_blocks(input int n_words);
    int left;
    int len;
    len  = block_len_in_force();
    left = n_words;
    while (left > 0) begin
      if ($urandom_range(0, 9) < 8) begin
        add_word(1'b1, pick_step(), pick_level());
        left--;
        for (int k = 1; k < len && left > 0; k++) begin
          add_word(1'b0, STEP_BITS'($urandom), LEVEL_BITS'($urandom));
          left--;
        end
      end else begin
        if ($urandom_range(0, 2) == 0) begin
          add_word(1'b1, pick_step(), pick_level());
        end else begin
          add_word(1'b0, STEP_BITS'($urandom), LEVEL_BITS'($urandom));
        end
        left--;
      end
    end
  endtask

  task automatic run_phase(input logic [31:0] gain, input logic [31:0] blen,
                           input int n_words, input bit idle);
    wait_idle();
    set_register(REG_MASTER_GAIN, gain);
    set_register(REG_BLOCK_LENGTH, blen);
    idle_on = idle;
    queue_blocks(n_words);
  endtask

  // Stimulus
  initial begin
    for (int i = 0; i <= QUARTER; i++) begin
      qwave[i] = quarter_entry(i);
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: short blocks at full gain
    set_register(REG_MASTER_GAIN, 32'hFFFF);
    set_register(REG_BLOCK_LENGTH, 32'd4);
    // level ramp from zero, stray words with all-ones fields
    add_word(1'b1, '0, '1);
    repeat (3) add_word(1'b0, '1, '1);
    // largest step ramp
    add_word(1'b1, '1, '1);
    repeat (3) add_word(1'b0, '0, '0);
    // steady block, then a level ramp down started inside it
    add_word(1'b1, '1, '1);
    add_word(1'b0, '0, '0);
    add_word(1'b1, '1, '0);
    add_word(1'b0, '0, '0);
    // abandon that ramp for a falling step ramp
    add_word(1'b1, '0, '0);
    repeat (3) add_word(1'b0, '0, '0);
    // increments that truncate to zero, then snap
    add_word(1'b1, 31'd3, '0);
    repeat (3) add_word(1'b0, '0, '0);
    add_word(1'b1, 31'd3, 16'd1);
    repeat (3) add_word(1'b0, '0, '0);
    gen_step  = 31'd3;
    gen_level = 16'd1;

    // Random phases over gains and block lengths, out-of-range ones too
    run_phase(32'hFFFF, 32'd1, 150, 1'b1);
    run_phase(32'h0000, 32'd3, 100, 1'b1);
    run_phase(32'($urandom_range(0, 65535)), 32'd0, 100, 1'b1);
    run_phase(32'($urandom_range(0, 65535)), 32'd16, 300, 1'b1);
    run_phase(32'($urandom_range(0, 65535)), 32'd8191, 120, 1'b1);
    run_phase(32'hFFFF, 32'd4096, 80, 1'b0);
    run_phase(32'($urandom_range(0, 65535)), 32'($urandom_range(2, 40)), 300, 1'b1);
    run_phase(32'($urandom_range(0, 65535)), 32'($urandom_range(2, 40)), 300, 1'b1);
    run_phase(32'($urandom_range(0, 65535)), 32'd7, 300, 1'b0);

    wait_idle();
    repeat (40) @(posedge clk_i);
    if (error_count == 0 && expected_samples.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
